FILE: rtl/core/audio_sample_ring_with_level_meter_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the audio sample ring core
// Short forms for clocked assertions that stay quiet during reset.
// ---------------------------------------------------------------------------
`ifndef AUDIO_SAMPLE_RING_WITH_LEVEL_METER_CORE_ASSERT_SVH
`define AUDIO_SAMPLE_RING_WITH_LEVEL_METER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASRLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASRLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/asrlm_pkg.sv
// ---------------------------------------------------------------------------
// asrlm_pkg
// Shared widths, operation codes and status types of the audio sample ring.
// ---------------------------------------------------------------------------
package asrlm_pkg;

    localparam int RING_DEPTH = 8192;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 32;
    localparam int SUM_W      = 63;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int RMS_W      = 16;
    localparam int RMS_MAX    = 32768;

    // Working widths of the divide and root engine.
    localparam int WORK_W     = 64;
    localparam int ITER_W     = $clog2(WORK_W);
    localparam int ROOT_W     = WORK_W / 2;
    localparam int REM_W      = ROOT_W + 1;
    localparam int ALU_W      = REM_W + 2;

    // Stream payload widths.
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 80;
    localparam int M_TUSER_W  = 1;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_STATS = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic             done;
        logic [RMS_W-1:0] rms;
    } eng_status_t;

endpackage

FILE: rtl/core/audio_sample_ring_with_level_meter_core.sv
// ---------------------------------------------------------------------------
// audio_sample_ring_with_level_meter_core
// Sample ring buffer with peak, count and RMS level metering.
// ---------------------------------------------------------------------------
// Each input transaction carries an operation in s_axis_tuser (push, pop,
// stats query, clear) and a signed 16-bit sample in s_axis_tdata. Every input
// transaction yields exactly one output transaction on the m_axis group.
// A push is taken only while capture is enabled through cfg_wr_en/cfg_wr_data,
// which may be written only while the core is idle.
// Steps per operation: a push squares the sample on acceptance, then adds the
// square into the 63-bit sum in ST_PUSH_ACC before ST_DONE; a pop, a clear, a
// disabled push and a stats query with zero count go straight to ST_DONE;
// a stats query with samples waits in ST_STATS for long division, then square
// root, on one shared 35-bit subtractor, before ST_DONE. The result enters
// the output register as the core leaves ST_DONE and becomes ready again.
// s_axis_tready is high only while idle.
// The next operation is accepted while an earlier result still waits; a
// stalled receiver holds the core only once a second result is ready.
// Reset clears pointers, statistics, capture enable and the output valid.
// The ring memory itself is not cleared; pops only reach written entries.
// ---------------------------------------------------------------------------
module audio_sample_ring_with_level_meter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration: bit 0 is capture_enable.
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [asrlm_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [15:0] sample
    input  logic [asrlm_pkg::S_TUSER_W-1:0]      s_axis_tuser,  // [1:0] operation
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] popped_sample, [47:16] sample_count, [63:48] peak_level,
    // [79:64] rms_level
    output logic [asrlm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic [asrlm_pkg::M_TUSER_W-1:0]      m_axis_tuser   // [0] popped_valid
);
    import asrlm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH_ACC,
        ST_STATS,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                cap_en_reg, cap_en_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SAMPLE_W-1:0] peak_reg, peak_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                pop_hit_reg, pop_hit_next;
    logic [RMS_W-1:0]    rms_res_reg, rms_res_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [M_TUSER_W-1:0] out_user_reg, out_user_next;

    // Ring storage with a registered read port.
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    op_t                 op;
    logic                in_fire;
    logic [SAMPLE_W:0]   neg_sample;
    logic [SAMPLE_W-1:0] abs_sample;
    logic                ring_empty;
    logic                mem_we;
    logic                mem_re;
    logic                eng_start;
    logic                out_load;
    logic [SAMPLE_W-1:0] popped_sample;
    eng_status_t         eng_status;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign op            = op_t'(s_axis_tuser);

    // Magnitude of a signed sample; the most negative value maps to 32768.
    assign neg_sample = {(SAMPLE_W + 1){1'b0}} - {s_axis_tdata[SAMPLE_W-1], s_axis_tdata};
    assign abs_sample = s_axis_tdata[SAMPLE_W-1] ? neg_sample[SAMPLE_W-1:0] : s_axis_tdata;

    // With no overrun check, equal pointers always read as an empty ring.
    assign ring_empty = (rp_reg == wp_reg);
    assign mem_we     = in_fire && (op == OP_PUSH) && cap_en_reg;
    assign mem_re     = in_fire && (op == OP_POP) && !ring_empty;
    assign eng_start  = in_fire && (op == OP_STATS) && (count_reg != '0);
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    assign popped_sample = pop_hit_reg ? rd_data_reg : '0;

    asrlm_stats_engine u_stats_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (eng_start),
        .sum    (sum_reg),
        .count  (count_reg),
        .status (eng_status)
    );

    always_comb
    begin
        state_next     = state_reg;
        cap_en_next    = cap_en_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        count_next     = count_reg;
        peak_next      = peak_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        pop_hit_next   = pop_hit_reg;
        rms_res_next   = rms_res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (cfg_wr_en)
        begin
            cap_en_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pop_hit_next = 1'b0;
                    rms_res_next = '0;
                    state_next   = ST_DONE;
                    unique case (op)
                        OP_PUSH:
                        begin
                            if (cap_en_reg)
                            begin
                                if (abs_sample > peak_reg)
                                begin
                                    peak_next = abs_sample;
                                end
                                prod_next  = {{SAMPLE_W{1'b0}}, abs_sample}
                                           * {{SAMPLE_W{1'b0}}, abs_sample};
                                wp_next    = wp_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                                state_next = ST_PUSH_ACC;
                            end
                        end
                        OP_POP:
                        begin
                            if (!ring_empty)
                            begin
                                pop_hit_next = 1'b1;
                                rp_next      = rp_reg + 1'b1;
                            end
                        end
                        OP_STATS:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_STATS;
                            end
                        end
                        OP_CLEAR:
                        begin
                            wp_next    = '0;
                            rp_next    = '0;
                            count_next = '0;
                            peak_next  = '0;
                            sum_next   = '0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PUSH_ACC:
            begin
                // The sum wraps at 63 bits.
                sum_next   = sum_reg + {{(SUM_W - PROD_W){1'b0}}, prod_reg};
                state_next = ST_DONE;
            end
            ST_STATS:
            begin
                if (eng_status.done)
                begin
                    rms_res_next = eng_status.rms;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: load a finished result, or drop a taken one.
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {rms_res_reg, peak_reg, count_reg, popped_sample};
            out_user_next  = pop_hit_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_en_reg    <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            sum_reg       <= '0;
            pop_hit_reg   <= 1'b0;
            rms_res_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_en_reg    <= cap_en_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            sum_reg       <= sum_next;
            pop_hit_reg   <= pop_hit_next;
            rms_res_reg   <= rms_res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // Single write port and single registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wp_reg] <= s_axis_tdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[rp_reg];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
`include "audio_sample_ring_with_level_meter_core_assert.svh"

    `ASRLM_ASSERT_NEXT(a_push_counts, in_fire && (op == OP_PUSH) && cap_en_reg, count_reg == $past(count_reg) + 1'b1, "accepted push did not advance the sample count")

    `ASRLM_ASSERT_NOW(a_eng_done_in_stats, eng_status.done, state_reg == ST_STATS, "stats engine finished outside a stats query")

    `ASRLM_ASSERT_NEXT(a_clear_resets, in_fire && (op == OP_CLEAR), (count_reg == '0) && (peak_reg == '0) && (sum_reg == '0) && (wp_reg == rp_reg), "clear left statistics or pointers set")

endmodule

FILE: rtl/core/asrlm_stats_engine.sv
// ---------------------------------------------------------------------------
// asrlm_stats_engine
// Mean square and floor root, one bit per cycle on a shared subtractor.
// ---------------------------------------------------------------------------
module asrlm_stats_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [asrlm_pkg::SUM_W-1:0]        sum,
    input  logic [asrlm_pkg::COUNT_W-1:0]      count,
    output asrlm_pkg::eng_status_t             status
);
    import asrlm_pkg::*;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_DIV,
        ENG_ROOT
    } eng_state_t;

    eng_state_t         state_reg, state_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [WORK_W-1:0]  work_reg, work_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [COUNT_W-1:0] divisor_reg, divisor_next;
    logic               done_reg, done_next;
    logic [RMS_W-1:0]   rms_reg, rms_next;

    logic [ALU_W-1:0]   op_a;
    logic [ALU_W-1:0]   op_b;
    logic [ALU_W:0]     diff;
    logic               ge;
    logic [ROOT_W-1:0]  root_new;

    // The one subtractor serves both the long division and the root.
    always_comb
    begin
        unique case (state_reg)
            ENG_DIV:
            begin
                op_a = {2'b00, rem_reg[COUNT_W-1:0], work_reg[WORK_W-1]};
                op_b = {3'b000, divisor_reg};
            end
            ENG_ROOT:
            begin
                op_a = {rem_reg, work_reg[WORK_W-1 -: 2]};
                op_b = {1'b0, root_reg, 2'b01};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        diff     = {1'b0, op_a} - {1'b0, op_b};
        ge       = !diff[ALU_W];
        root_new = {root_reg[ROOT_W-2:0], ge};
    end

    always_comb
    begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        divisor_next = divisor_reg;
        done_next    = 1'b0;
        rms_next     = rms_reg;

        unique case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    work_next    = {{(WORK_W - SUM_W){1'b0}}, sum};
                    divisor_next = count;
                    rem_next     = '0;
                    root_next    = '0;
                    iter_next    = '0;
                    state_next   = ENG_DIV;
                end
            end
            ENG_DIV:
            begin
                // Restoring division: dividend bits leave at the top, quotient
                // bits enter at the bottom of the same register.
                rem_next  = ge ? {1'b0, diff[COUNT_W-1:0]} : {1'b0, op_a[COUNT_W-1:0]};
                work_next = {work_reg[WORK_W-2:0], ge};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(WORK_W - 1))
                begin
                    // The root starts from an empty remainder.
                    rem_next   = '0;
                    iter_next  = '0;
                    state_next = ENG_ROOT;
                end
            end
            ENG_ROOT:
            begin
                // Digit-by-digit root, two radicand bits per step.
                rem_next  = ge ? diff[REM_W-1:0] : op_a[REM_W-1:0];
                work_next = {work_reg[WORK_W-3:0], 2'b00};
                root_next = root_new;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    iter_next  = '0;
                    done_next  = 1'b1;
                    rms_next   = (root_new > ROOT_W'(RMS_MAX)) ? RMS_W'(RMS_MAX)
                                                              : root_new[RMS_W-1:0];
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        divisor_reg <= divisor_next;
        rms_reg     <= rms_next;
    end

    assign status.done = done_reg;
    assign status.rms  = rms_reg;

endmodule
